/* src/gnz_pkg.sv */
package gnz_pkg;

   localparam int TABLE_SIZE_DEF      = 256;
   localparam int COORD_FRAC_BITS_DEF = 16;

   localparam int MODE_W  = 2;
   localparam int IDX_W   = 8;
   localparam int GRAD_W  = 16;
   localparam int PERM_W  = 8;
   localparam int COORD_W = 32;
   localparam int NOISE_W = 16;
   localparam int DOT_W   = 18;
   localparam int CORNERS = 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_EVAL = 2'd0,
      MODE_GRAD = 2'd1,
      MODE_PERM = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

endpackage

/* src/gnz_if.sv */
interface gnz_req_if;
   import gnz_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [MODE_W-1:0]         mode;
   logic [IDX_W-1:0]          index;
   logic signed [GRAD_W-1:0]  grad_x;
   logic signed [GRAD_W-1:0]  grad_y;
   logic signed [GRAD_W-1:0]  grad_z;
   logic [PERM_W-1:0]         perm_value;
   logic signed [COORD_W-1:0] point_x;
   logic signed [COORD_W-1:0] point_y;
   logic signed [COORD_W-1:0] point_z;
   modport source (output valid, mode, index, grad_x, grad_y, grad_z, perm_value,
      point_x, point_y, point_z, input ready);
   modport sink (input valid, mode, index, grad_x, grad_y, grad_z, perm_value,
      point_x, point_y, point_z, output ready);
endinterface

interface gnz_rsp_if;
   import gnz_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [NOISE_W-1:0] noise_value;
   modport source (output valid, noise_value, input ready);
   modport sink (input valid, noise_value, output ready);
endinterface

/* src/gnz_ram.sv */
module gnz_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

/* src/gnz_lookup.sv */
module gnz_lookup import gnz_pkg::*; #(
   parameter int TABLE_SIZE      = TABLE_SIZE_DEF,
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   gnz_req_if.sink                           req,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [COORD_FRAC_BITS-1:0]        out_tx,
   output logic [COORD_FRAC_BITS-1:0]        out_ty,
   output logic [COORD_FRAC_BITS-1:0]        out_tz,
   output logic signed [3*GRAD_W-1:0]        out_grad [CORNERS]
);

   localparam int F  = COORD_FRAC_BITS;
   localparam int IW = $clog2(TABLE_SIZE);
   localparam int EW = (IW > PERM_W) ? IW : PERM_W;
   localparam int CW = F + IW;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic en1, en2, en3, en4;

   mode_type            mode1_ff, mode2_ff, mode3_ff;
   logic [IW-1:0]       widx1_ff, widx2_ff, widx3_ff;
   logic [PERM_W-1:0]   pv1_ff, pv2_ff;
   logic [3*GRAD_W-1:0] g1_ff, g2_ff, g3_ff;
   logic [F-1:0]        tx1_ff, ty1_ff, tz1_ff, tx2_ff, ty2_ff, tz2_ff;
   logic [F-1:0]        tx3_ff, ty3_ff, tz3_ff, tx4_ff, ty4_ff, tz4_ff;
   logic [IW-1:0]       cy1_ff [2];
   logic [IW-1:0]       cz1_ff [2];
   logic [IW-1:0]       cz2_ff [2];

   logic signed [CW-1:0] px_e, py_e, pz_e;
   logic [IW-1:0]        cx0, cy0, cz0, widx0;
   logic [IW-1:0]        addr_a [2];
   logic [IW-1:0]        addr_b [4];
   logic [IW-1:0]        addr_c [CORNERS];
   logic [IW-1:0]        addr_g [CORNERS];
   logic [PERM_W-1:0]    pa [2];
   logic [PERM_W-1:0]    pb [4];
   logic [PERM_W-1:0]    pc [CORNERS];

   assign en4 = !v4_ff || out_ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req.ready = en1;

   assign v1_in = en1 ? req.valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;
   assign v4_in = en4 ? (v3_ff && mode3_ff == MODE_EVAL) : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   assign px_e  = CW'(req.point_x);
   assign py_e  = CW'(req.point_y);
   assign pz_e  = CW'(req.point_z);
   assign cx0   = px_e[CW-1:F];
   assign cy0   = py_e[CW-1:F];
   assign cz0   = pz_e[CW-1:F];
   assign widx0 = IW'(EW'(req.index));

   always_ff @(posedge clock) begin
      if (en1) begin
         mode1_ff  <= mode_type'(req.mode);
         widx1_ff  <= widx0;
         pv1_ff    <= req.perm_value;
         g1_ff     <= {req.grad_x, req.grad_y, req.grad_z};
         tx1_ff    <= req.point_x[F-1:0];
         ty1_ff    <= req.point_y[F-1:0];
         tz1_ff    <= req.point_z[F-1:0];
         cy1_ff[0] <= cy0;
         cy1_ff[1] <= cy0 + IW'(1);
         cz1_ff[0] <= cz0;
         cz1_ff[1] <= cz0 + IW'(1);
      end
      if (en2) begin
         mode2_ff  <= mode1_ff;
         widx2_ff  <= widx1_ff;
         pv2_ff    <= pv1_ff;
         g2_ff     <= g1_ff;
         tx2_ff    <= tx1_ff;
         ty2_ff    <= ty1_ff;
         tz2_ff    <= tz1_ff;
         cz2_ff    <= cz1_ff;
      end
      if (en3) begin
         mode3_ff  <= mode2_ff;
         widx3_ff  <= widx2_ff;
         g3_ff     <= g2_ff;
         tx3_ff    <= tx2_ff;
         ty3_ff    <= ty2_ff;
         tz3_ff    <= tz2_ff;
      end
      if (en4) begin
         tx4_ff    <= tx3_ff;
         ty4_ff    <= ty3_ff;
         tz4_ff    <= tz3_ff;
      end
   end

   assign addr_a[0] = cx0;
   assign addr_a[1] = cx0 + IW'(1);

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         addr_b[j] = IW'(EW'(pa[j % 2])) + cy1_ff[j / 2];
      end
      for (int c = 0; c < CORNERS; c++) begin
         addr_c[c] = IW'(EW'(pb[c % 4])) + cz2_ff[c / 4];
         addr_g[c] = IW'(EW'(pc[c]));
      end
   end

   for (genvar i = 0; i < 2; i++) begin : g_perm_a
      gnz_ram #(.DEPTH(TABLE_SIZE), .WIDTH(PERM_W)) u_ram (
         .clock   (clock),
         .wr_en   (en1 && req.valid && mode_type'(req.mode) == MODE_PERM),
         .wr_addr (widx0),
         .wr_data (req.perm_value),
         .rd_en   (en1),
         .rd_addr (addr_a[i]),
         .rd_data (pa[i])
      );
   end

   for (genvar i = 0; i < 4; i++) begin : g_perm_b
      gnz_ram #(.DEPTH(TABLE_SIZE), .WIDTH(PERM_W)) u_ram (
         .clock   (clock),
         .wr_en   (en2 && v1_ff && mode1_ff == MODE_PERM),
         .wr_addr (widx1_ff),
         .wr_data (pv1_ff),
         .rd_en   (en2),
         .rd_addr (addr_b[i]),
         .rd_data (pb[i])
      );
   end

   for (genvar i = 0; i < CORNERS; i++) begin : g_perm_c
      gnz_ram #(.DEPTH(TABLE_SIZE), .WIDTH(PERM_W)) u_ram (
         .clock   (clock),
         .wr_en   (en3 && v2_ff && mode2_ff == MODE_PERM),
         .wr_addr (widx2_ff),
         .wr_data (pv2_ff),
         .rd_en   (en3),
         .rd_addr (addr_c[i]),
         .rd_data (pc[i])
      );
   end

   for (genvar i = 0; i < CORNERS; i++) begin : g_grad
      gnz_ram #(.DEPTH(TABLE_SIZE), .WIDTH(3*GRAD_W)) u_ram (
         .clock   (clock),
         .wr_en   (en4 && v3_ff && mode3_ff == MODE_GRAD),
         .wr_addr (widx3_ff),
         .wr_data (g3_ff),
         .rd_en   (en4),
         .rd_addr (addr_g[i]),
         .rd_data (out_grad[i])
      );
   end

   assign out_valid = v4_ff;
   assign out_tx    = tx4_ff;
   assign out_ty    = ty4_ff;
   assign out_tz    = tz4_ff;

endmodule

/* src/gnz_blend.sv */
module gnz_blend import gnz_pkg::*; #(
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [COORD_FRAC_BITS-1:0]  in_tx,
   input  logic [COORD_FRAC_BITS-1:0]  in_ty,
   input  logic [COORD_FRAC_BITS-1:0]  in_tz,
   input  logic signed [3*GRAD_W-1:0]  in_grad [CORNERS],
   gnz_rsp_if.source                   rsp
);

   localparam int F   = COORD_FRAC_BITS;
   localparam int MW  = GRAD_W + F + 1;
   localparam int DSW = MW + 2;
   localparam int PW  = DOT_W + F + 2;
   localparam int SW  = PW + 1;
   localparam logic signed [DSW-1:0] DHALF = DSW'(1) <<< (F - 1);
   localparam logic signed [SW-1:0]  BHALF = SW'(1) <<< (F - 1);
   localparam logic [F:0]            ONE   = (F + 1)'(1) << F;

   logic v5_ff, v6_ff, v7_ff, v8_ff, v9_ff;
   logic v5_in, v6_in, v7_in, v8_in, v9_in;
   logic en5, en6, en7, en8, en9;

   logic [F-1:0] tx5_ff, ty5_ff, tz5_ff, tx6_ff, ty6_ff, tz6_ff;
   logic [F-1:0] ty7_ff, tz7_ff, tz8_ff;

   logic signed [MW-1:0]      prod_ff [CORNERS][3];
   logic signed [MW-1:0]      prod_in [CORNERS][3];
   logic signed [DOT_W-1:0]   dot_ff  [CORNERS];
   logic signed [DOT_W-1:0]   dot_in  [CORNERS];
   logic signed [DOT_W-1:0]   bx_ff   [4];
   logic signed [DOT_W-1:0]   bx_in   [4];
   logic signed [DOT_W-1:0]   by_ff   [2];
   logic signed [DOT_W-1:0]   by_in   [2];
   logic signed [NOISE_W-1:0] res_ff;
   logic signed [NOISE_W-1:0] res_in;

   logic signed [F+1:0]     wx, sx, wy, sy, wz, sz;
   logic signed [F:0]       off [3][2];
   logic [F-1:0]            tsel [3];
   logic signed [DSW-1:0]   dsum [CORNERS];
   logic signed [DSW-1:0]   dsh  [CORNERS];
   logic signed [PW-1:0]    pxl [4];
   logic signed [PW-1:0]    pxh [4];
   logic signed [SW-1:0]    sxs [4];
   logic signed [PW-1:0]    pyl [2];
   logic signed [PW-1:0]    pyh [2];
   logic signed [SW-1:0]    sys [2];
   logic signed [PW-1:0]    pzl, pzh;
   logic signed [SW-1:0]    szs;
   logic signed [DOT_W-1:0] rz;

   assign en9 = !v9_ff || rsp.ready;
   assign en8 = !v8_ff || en9;
   assign en7 = !v7_ff || en8;
   assign en6 = !v6_ff || en7;
   assign en5 = !v5_ff || en6;
   assign in_ready = en5;

   assign v5_in = en5 ? in_valid : v5_ff;
   assign v6_in = en6 ? v5_ff : v6_ff;
   assign v7_in = en7 ? v6_ff : v7_ff;
   assign v8_in = en8 ? v7_ff : v8_ff;
   assign v9_in = en9 ? v8_ff : v9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else begin
         v5_ff <= v5_in;
         v6_ff <= v6_in;
         v7_ff <= v7_in;
         v8_ff <= v8_in;
         v9_ff <= v9_in;
      end
   end

   assign tsel[0] = in_tx;
   assign tsel[1] = in_ty;
   assign tsel[2] = in_tz;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         off[k][0] = $signed({1'b0, tsel[k]});
         off[k][1] = $signed({1'b1, tsel[k]});
      end
      for (int c = 0; c < CORNERS; c++) begin
         prod_in[c][0] = MW'($signed(in_grad[c][3*GRAD_W-1:2*GRAD_W]))
            * MW'(off[0][c % 2]);
         prod_in[c][1] = MW'($signed(in_grad[c][2*GRAD_W-1:GRAD_W]))
            * MW'(off[1][(c / 2) % 2]);
         prod_in[c][2] = MW'($signed(in_grad[c][GRAD_W-1:0])) * MW'(off[2][c / 4]);
      end
   end

   always_comb begin
      for (int c = 0; c < CORNERS; c++) begin
         dsum[c]   = DSW'(prod_ff[c][0]) + DSW'(prod_ff[c][1]) + DSW'(prod_ff[c][2]) + DHALF;
         dsh[c]    = dsum[c] >>> F;
         dot_in[c] = dsh[c][DOT_W-1:0];
      end
   end

   assign wx = $signed({1'b0, ONE - {1'b0, tx6_ff}});
   assign sx = $signed({2'b00, tx6_ff});
   assign wy = $signed({1'b0, ONE - {1'b0, ty7_ff}});
   assign sy = $signed({2'b00, ty7_ff});
   assign wz = $signed({1'b0, ONE - {1'b0, tz8_ff}});
   assign sz = $signed({2'b00, tz8_ff});

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         pxl[j]   = PW'(dot_ff[2*j]) * PW'(wx);
         pxh[j]   = PW'(dot_ff[2*j+1]) * PW'(sx);
         sxs[j]   = (SW'(pxl[j]) + SW'(pxh[j]) + BHALF) >>> F;
         bx_in[j] = sxs[j][DOT_W-1:0];
      end
      for (int k = 0; k < 2; k++) begin
         pyl[k]   = PW'(bx_ff[2*k]) * PW'(wy);
         pyh[k]   = PW'(bx_ff[2*k+1]) * PW'(sy);
         sys[k]   = (SW'(pyl[k]) + SW'(pyh[k]) + BHALF) >>> F;
         by_in[k] = sys[k][DOT_W-1:0];
      end
   end

   always_comb begin
      pzl = PW'(by_ff[0]) * PW'(wz);
      pzh = PW'(by_ff[1]) * PW'(sz);
      szs = (SW'(pzl) + SW'(pzh) + BHALF) >>> F;
      rz  = szs[DOT_W-1:0];
      if (rz > DOT_W'(32767)) begin
         res_in = NOISE_W'(32767);
      end else if (rz < -DOT_W'(32768)) begin
         res_in = NOISE_W'(-32768);
      end else begin
         res_in = rz[NOISE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         prod_ff <= prod_in;
         tx5_ff  <= in_tx;
         ty5_ff  <= in_ty;
         tz5_ff  <= in_tz;
      end
      if (en6) begin
         dot_ff  <= dot_in;
         tx6_ff  <= tx5_ff;
         ty6_ff  <= ty5_ff;
         tz6_ff  <= tz5_ff;
      end
      if (en7) begin
         bx_ff   <= bx_in;
         ty7_ff  <= ty6_ff;
         tz7_ff  <= tz6_ff;
      end
      if (en8) begin
         by_ff   <= by_in;
         tz8_ff  <= tz7_ff;
      end
      if (en9) begin
         res_ff  <= res_in;
      end
   end

   assign rsp.valid       = v9_ff;
   assign rsp.noise_value = res_ff;

`ifndef SYNTHESIS
   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> (v5_ff && v6_ff && v7_ff && v8_ff && v9_ff))
      else $error("blend pipe blocked with a bubble");
   a_y_to_z: assert property (@(posedge clock) disable iff (reset)
      (v8_ff && en9) |=> v9_ff)
      else $error("request lost between last stages");
   a_dot_to_x: assert property (@(posedge clock) disable iff (reset)
      (v6_ff && en7) |=> v7_ff)
      else $error("request lost after dot stage");
`endif

endmodule

/* src/gradient_noise_3d_eval_unit.sv */
// A point request passes 4 table lookup stages, then dot product, dot sum and three
//   blend stages; one request is taken per cycle unless the response side stalls.
// Each table read port is its own copy.
// Load requests write the tables and give no result; mode 3 is dropped.
// Reset clears the pipeline valid bits only; the tables are undefined until loaded.
module gradient_noise_3d_eval_unit import gnz_pkg::*; #(
   parameter int TABLE_SIZE      = TABLE_SIZE_DEF,
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   gnz_req_if.sink  req_ch,
   gnz_rsp_if.source rsp_ch
);

   logic                          lk_valid, lk_ready;
   logic [COORD_FRAC_BITS-1:0]    lk_tx, lk_ty, lk_tz;
   logic signed [3*GRAD_W-1:0]    lk_grad [CORNERS];

   gnz_lookup #(
      .TABLE_SIZE      (TABLE_SIZE),
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_lookup (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .out_valid (lk_valid),
      .out_ready (lk_ready),
      .out_tx    (lk_tx),
      .out_ty    (lk_ty),
      .out_tz    (lk_tz),
      .out_grad  (lk_grad)
   );

   gnz_blend #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_blend (
      .clock    (clock),
      .reset    (reset),
      .in_valid (lk_valid),
      .in_ready (lk_ready),
      .in_tx    (lk_tx),
      .in_ty    (lk_ty),
      .in_tz    (lk_tz),
      .in_grad  (lk_grad),
      .rsp      (rsp_ch)
   );

endmodule
